// ===== hw/rtl/bop_pkg.sv =====
// Shared types and constants for the band overlap projector.
// Used by bop_front, bop_back and band_overlap_projector; depends on nothing.
`default_nettype none

package bop_pkg;

    localparam int WEIGHT_W   = 16;
    localparam int OVL_W      = 24;
    localparam int OVL_FRAC   = 23;
    localparam int POWER_W    = 48;
    localparam int HALF_PW    = 24;
    localparam int TOTAL_W    = 63;
    localparam int WPROD_W    = 64;
    localparam int OUT_DATA_W = 224;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Per-band side information that travels with the finished accumulators.
    typedef struct packed {
        logic                occupied;
        logic [WEIGHT_W-1:0] weight;
        logic                run_end;
    } band_meta_t;

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_ROUND   = 7'b0000010,
        ST_SQUARE  = 7'b0000100,
        ST_POWER   = 7'b0001000,
        ST_WEIGHT  = 7'b0010000,
        ST_COMBINE = 7'b0100000,
        ST_TOTAL   = 7'b1000000
    } back_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bop_front.sv =====
// Front end: registers coefficient pairs, multiplies them and accumulates the
// conjugate product per band; pushes the finished band into the queue.
// Depends on bop_pkg.
`default_nettype none

module bop_front #(
    parameter int CW    = 16,
    parameter int ACC_W = 48
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       in_valid,
    output logic                      in_ready,
    input  wire  signed [CW-1:0]      proj_re,
    input  wire  signed [CW-1:0]      proj_im,
    input  wire  signed [CW-1:0]      ref_re,
    input  wire  signed [CW-1:0]      ref_im,
    input  wire                       last_coeff,
    input  wire bop_pkg::band_meta_t  meta,
    output logic                      push_valid,
    input  wire                       push_ready,
    output logic signed [ACC_W-1:0]   push_acc_re,
    output logic signed [ACC_W-1:0]   push_acc_im,
    output bop_pkg::band_meta_t       push_meta
);

    localparam int PROD_W = 2 * CW;
    localparam int SUMX_W = PROD_W + 1;
    localparam int SUM_W  = (SUMX_W > 64) ? 64 : SUMX_W;
    localparam int ADD_W  = ((ACC_W > SUM_W) ? ACC_W : SUM_W) + 1;

    logic                     enable;

    logic                     s1_valid_reg, s1_valid_next;
    logic signed [CW-1:0]     s1_pr_reg, s1_pi_reg, s1_rr_reg, s1_ri_reg;
    logic                     s1_last_reg;
    bop_pkg::band_meta_t      s1_meta_reg;

    logic                     s2_valid_reg, s2_valid_next;
    logic signed [PROD_W-1:0] s2_p_rr_reg, s2_p_ii_reg, s2_p_ir_reg, s2_p_ri_reg;
    logic signed [PROD_W-1:0] p_rr_c, p_ii_c, p_ir_c, p_ri_c;
    logic                     s2_last_reg;
    bop_pkg::band_meta_t      s2_meta_reg;

    logic                     s3_valid_reg, s3_valid_next;
    logic signed [SUM_W-1:0]  s3_sre_reg, s3_sim_reg;
    logic signed [SUMX_W-1:0] sre_x, sim_x;
    logic signed [SUM_W-1:0]  sre_c, sim_c;
    logic                     s3_last_reg;
    bop_pkg::band_meta_t      s3_meta_reg;

    logic signed [ACC_W-1:0]  acc_re_reg, acc_re_next;
    logic signed [ACC_W-1:0]  acc_im_reg, acc_im_next;
    logic signed [ACC_W-1:0]  acc_re_sum, acc_im_sum;
    logic signed [ADD_W-1:0]  add_re_x, add_im_x;
    logic                     band_end;

    // The whole pipe holds only when a band end cannot enter the queue.
    assign band_end = s3_valid_reg && s3_last_reg;
    assign enable   = !(band_end && !push_ready);
    assign in_ready = enable;

    assign s1_valid_next = enable ? in_valid : s1_valid_reg;
    assign s2_valid_next = enable ? s1_valid_reg : s2_valid_reg;
    assign s3_valid_next = enable ? s2_valid_reg : s3_valid_reg;

    assign p_rr_c = s1_pr_reg * s1_rr_reg;
    assign p_ii_c = s1_pi_reg * s1_ri_reg;
    assign p_ir_c = s1_pi_reg * s1_rr_reg;
    assign p_ri_c = s1_pr_reg * s1_ri_reg;

    assign sre_x = SUMX_W'(s2_p_rr_reg) + SUMX_W'(s2_p_ii_reg);
    assign sim_x = SUMX_W'(s2_p_ir_reg) - SUMX_W'(s2_p_ri_reg);

    generate
        if (SUMX_W > SUM_W) begin : g_sum_sat
            always_comb
            begin
                if (sre_x[SUMX_W-1] != sre_x[SUMX_W-2])
                begin
                    sre_c = sre_x[SUMX_W-1] ? {1'b1, {(SUM_W-1){1'b0}}}
                                            : {1'b0, {(SUM_W-1){1'b1}}};
                end
                else
                begin
                    sre_c = sre_x[SUM_W-1:0];
                end
                if (sim_x[SUMX_W-1] != sim_x[SUMX_W-2])
                begin
                    sim_c = sim_x[SUMX_W-1] ? {1'b1, {(SUM_W-1){1'b0}}}
                                            : {1'b0, {(SUM_W-1){1'b1}}};
                end
                else
                begin
                    sim_c = sim_x[SUM_W-1:0];
                end
            end
        end
        else begin : g_sum_plain
            assign sre_c = sre_x;
            assign sim_c = sim_x;
        end
    endgenerate

    assign add_re_x = ADD_W'(acc_re_reg) + ADD_W'(s3_sre_reg);
    assign add_im_x = ADD_W'(acc_im_reg) + ADD_W'(s3_sim_reg);

    // Saturate when the accumulator's sign bit and the bits above it do not all agree.
    always_comb
    begin
        if ((&add_re_x[ADD_W-1:ACC_W-1]) || !(|add_re_x[ADD_W-1:ACC_W-1]))
        begin
            acc_re_sum = add_re_x[ACC_W-1:0];
        end
        else
        begin
            acc_re_sum = add_re_x[ADD_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                           : {1'b0, {(ACC_W-1){1'b1}}};
        end
        if ((&add_im_x[ADD_W-1:ACC_W-1]) || !(|add_im_x[ADD_W-1:ACC_W-1]))
        begin
            acc_im_sum = add_im_x[ACC_W-1:0];
        end
        else
        begin
            acc_im_sum = add_im_x[ADD_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                           : {1'b0, {(ACC_W-1){1'b1}}};
        end
    end

    always_comb
    begin
        acc_re_next = acc_re_reg;
        acc_im_next = acc_im_reg;
        if (s3_valid_reg && enable)
        begin
            if (s3_last_reg)
            begin
                acc_re_next = '0;
                acc_im_next = '0;
            end
            else
            begin
                acc_re_next = acc_re_sum;
                acc_im_next = acc_im_sum;
            end
        end
    end

    assign push_valid  = band_end;
    assign push_acc_re = acc_re_sum;
    assign push_acc_im = acc_im_sum;
    assign push_meta   = s3_meta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            acc_re_reg   <= '0;
            acc_im_reg   <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
            acc_re_reg   <= acc_re_next;
            acc_im_reg   <= acc_im_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            s1_pr_reg   <= proj_re;
            s1_pi_reg   <= proj_im;
            s1_rr_reg   <= ref_re;
            s1_ri_reg   <= ref_im;
            s1_last_reg <= last_coeff;
            s1_meta_reg <= meta;

            s2_p_rr_reg <= p_rr_c;
            s2_p_ii_reg <= p_ii_c;
            s2_p_ir_reg <= p_ir_c;
            s2_p_ri_reg <= p_ri_c;
            s2_last_reg <= s1_last_reg;
            s2_meta_reg <= s1_meta_reg;

            s3_sre_reg  <= sre_c;
            s3_sim_reg  <= sim_c;
            s3_last_reg <= s2_last_reg;
            s3_meta_reg <= s2_meta_reg;
        end
    end

    a_band_end_clears_acc : assert property (
        @(posedge clk) disable iff (!rst_n)
        (band_end && enable) |=> (acc_re_reg == '0 && acc_im_reg == '0)
    ) else $error("accumulators not cleared after a band end");

endmodule

`default_nettype wire

// ===== hw/rtl/bop_queue.sv =====
// Small first-in first-out queue of finished bands between front and back.
// Flip-flop storage; no package dependency.
`default_nettype none

module bop_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               push_valid,
    output logic              push_ready,
    input  wire  [WIDTH-1:0]  push_data,
    output logic              pop_valid,
    input  wire               pop_ready,
    output logic [WIDTH-1:0]  pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != (AW+1)'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_in_range : assert property (
        @(posedge clk) disable iff (!rst_n)
        count_reg <= (AW+1)'(DEPTH)
    ) else $error("queue fill count beyond depth");

endmodule

`default_nettype wire

// ===== hw/rtl/bop_back.sv =====
// Back end: rounds a finished band to Q1.23, squares and weights it, updates
// the valence or conduction total, clears both after a run's last band and
// holds the result for the output. Depends on bop_pkg.
`default_nettype none

module bop_back #(
    parameter int CW    = 16,
    parameter int ACC_W = 48
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  pop_valid,
    output logic                                 pop_ready,
    input  wire  signed [ACC_W-1:0]              pop_acc_re,
    input  wire  signed [ACC_W-1:0]              pop_acc_im,
    input  wire bop_pkg::band_meta_t             pop_meta,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output logic signed [bop_pkg::OVL_W-1:0]     overlap_re,
    output logic signed [bop_pkg::OVL_W-1:0]     overlap_im,
    output logic        [bop_pkg::POWER_W-1:0]   overlap_power,
    output logic        [bop_pkg::TOTAL_W-1:0]   valence_sum,
    output logic        [bop_pkg::TOTAL_W-1:0]   conduction_sum,
    output logic                                 run_done
);

    localparam int OVL_W     = bop_pkg::OVL_W;
    localparam int POWER_W   = bop_pkg::POWER_W;
    localparam int HALF_PW   = bop_pkg::HALF_PW;
    localparam int WEIGHT_W  = bop_pkg::WEIGHT_W;
    localparam int TOTAL_W   = bop_pkg::TOTAL_W;
    localparam int WPROD_W   = bop_pkg::WPROD_W;
    localparam int PART_W    = HALF_PW + WEIGHT_W;
    localparam int PROD_FRAC = 2 * (CW - 1);
    localparam int SH_R = (PROD_FRAC > bop_pkg::OVL_FRAC) ? PROD_FRAC - bop_pkg::OVL_FRAC : 1;
    localparam int SH_L = (PROD_FRAC > bop_pkg::OVL_FRAC) ? 0 : bop_pkg::OVL_FRAC - PROD_FRAC;

    localparam logic signed [63:0] Q_MAX = 64'sd8388607;
    localparam logic signed [63:0] Q_MIN = -64'sd8388608;
    localparam logic signed [63:0] C_HI  = 64'sd1099511627776;
    localparam logic signed [63:0] C_LO  = -64'sd1099511627776;

    // Accumulator value to Q1.23, rounding half up, with saturation.
    function automatic logic signed [OVL_W-1:0] round_q23(input logic signed [63:0] v);
        logic signed [63:0] r;
        if (PROD_FRAC > bop_pkg::OVL_FRAC)
        begin
            r = v >>> SH_R;
            r = r + $signed({63'b0, v[SH_R-1]});
        end
        else
        begin
            r = v;
            if (r > C_HI)
            begin
                r = C_HI;
            end
            else if (r < C_LO)
            begin
                r = C_LO;
            end
            r = r <<< SH_L;
        end
        if (r > Q_MAX)
        begin
            r = Q_MAX;
        end
        else if (r < Q_MIN)
        begin
            r = Q_MIN;
        end
        return r[OVL_W-1:0];
    endfunction

    bop_pkg::back_state_t        state_reg, state_next;
    logic signed [ACC_W-1:0]     acc_re_reg, acc_im_reg;
    bop_pkg::band_meta_t         meta_reg;
    logic signed [OVL_W-1:0]     ore_reg, oim_reg;
    logic signed [2*OVL_W-1:0]   sq_re_c, sq_im_c;
    logic        [POWER_W-1:0]   sq_re_reg, sq_im_reg;
    logic        [POWER_W-1:0]   power_reg;
    logic        [PART_W-1:0]    wlo_reg, whi_reg;
    logic        [WPROD_W-1:0]   wp_reg;
    logic        [TOTAL_W-1:0]   val_reg, val_next;
    logic        [TOTAL_W-1:0]   cond_reg, cond_next;
    logic        [TOTAL_W:0]     tot_x;
    logic        [TOTAL_W-1:0]   tot_new;
    logic                        out_valid_reg, out_valid_next;
    logic signed [OVL_W-1:0]     out_re_reg, out_im_reg;
    logic        [POWER_W-1:0]   out_power_reg;
    logic        [TOTAL_W-1:0]   out_val_reg, out_cond_reg;
    logic                        out_done_reg;
    logic                        slot_free, load_out;

    assign pop_ready = (state_reg == bop_pkg::ST_IDLE);
    assign slot_free = !out_valid_reg || out_ready;
    assign load_out  = (state_reg == bop_pkg::ST_TOTAL) && slot_free;

    assign sq_re_c = ore_reg * ore_reg;
    assign sq_im_c = oim_reg * oim_reg;

    // A total plus weighted power (below 2^63) needs the extra bit before clamping.
    assign tot_x   = (TOTAL_W+1)'(meta_reg.occupied ? val_reg : cond_reg)
                   + (TOTAL_W+1)'(wp_reg);
    assign tot_new = (tot_x > {1'b0, bop_pkg::TOTAL_MAX}) ? bop_pkg::TOTAL_MAX
                                                          : tot_x[TOTAL_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bop_pkg::ST_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = bop_pkg::ST_ROUND;
                end
            end
            bop_pkg::ST_ROUND:   state_next = bop_pkg::ST_SQUARE;
            bop_pkg::ST_SQUARE:  state_next = bop_pkg::ST_POWER;
            bop_pkg::ST_POWER:   state_next = bop_pkg::ST_WEIGHT;
            bop_pkg::ST_WEIGHT:  state_next = bop_pkg::ST_COMBINE;
            bop_pkg::ST_COMBINE: state_next = bop_pkg::ST_TOTAL;
            bop_pkg::ST_TOTAL:
            begin
                if (slot_free)
                begin
                    state_next = bop_pkg::ST_IDLE;
                end
            end
            default:             state_next = bop_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        val_next       = val_reg;
        cond_next      = cond_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
            if (meta_reg.run_end)
            begin
                val_next  = '0;
                cond_next = '0;
            end
            else if (meta_reg.occupied)
            begin
                val_next = tot_new;
            end
            else
            begin
                cond_next = tot_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bop_pkg::ST_IDLE;
            val_reg       <= '0;
            cond_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            val_reg       <= val_next;
            cond_reg      <= cond_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_valid && pop_ready)
        begin
            acc_re_reg <= pop_acc_re;
            acc_im_reg <= pop_acc_im;
            meta_reg   <= pop_meta;
        end
        if (state_reg == bop_pkg::ST_ROUND)
        begin
            ore_reg <= round_q23(64'(acc_re_reg));
            oim_reg <= round_q23(64'(acc_im_reg));
        end
        if (state_reg == bop_pkg::ST_SQUARE)
        begin
            sq_re_reg <= sq_re_c;
            sq_im_reg <= sq_im_c;
        end
        if (state_reg == bop_pkg::ST_POWER)
        begin
            power_reg <= sq_re_reg + sq_im_reg;
        end
        if (state_reg == bop_pkg::ST_WEIGHT)
        begin
            wlo_reg <= power_reg[HALF_PW-1:0] * meta_reg.weight;
            whi_reg <= power_reg[POWER_W-1:HALF_PW] * meta_reg.weight;
        end
        if (state_reg == bop_pkg::ST_COMBINE)
        begin
            wp_reg <= WPROD_W'(wlo_reg) + (WPROD_W'(whi_reg) << HALF_PW);
        end
        if (load_out)
        begin
            out_re_reg    <= ore_reg;
            out_im_reg    <= oim_reg;
            out_power_reg <= power_reg;
            out_val_reg   <= (meta_reg.occupied) ? tot_new : val_reg;
            out_cond_reg  <= (meta_reg.occupied) ? cond_reg : tot_new;
            out_done_reg  <= meta_reg.run_end;
        end
    end

    assign out_valid      = out_valid_reg;
    assign overlap_re     = out_re_reg;
    assign overlap_im     = out_im_reg;
    assign overlap_power  = out_power_reg;
    assign valence_sum    = out_val_reg;
    assign conduction_sum = out_cond_reg;
    assign run_done       = out_done_reg;

    a_run_end_clears_totals : assert property (
        @(posedge clk) disable iff (!rst_n)
        (load_out && meta_reg.run_end) |=> (val_reg == '0 && cond_reg == '0)
    ) else $error("totals not cleared after the last band of a run");

    // Both parts at the negative limit give the largest power, exactly 2^47.
    a_power_in_range : assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == bop_pkg::ST_WEIGHT)
            |-> (power_reg <= {1'b1, {(POWER_W-1){1'b0}}})
    ) else $error("overlap power beyond the Q1.23 square range");

    a_total_holds_for_slot : assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == bop_pkg::ST_TOTAL && !slot_free) |=> (state_reg == bop_pkg::ST_TOTAL)
    ) else $error("band left the total step while the result slot was busy");

endmodule

`default_nettype wire

// ===== hw/rtl/band_overlap_projector.sv =====
// Top level of the band overlap projector: unpacks the streams and joins the
// front end, the band queue and the back end. Depends on bop_pkg, bop_front,
// bop_queue and bop_back.
//
//   Channel  Direction  Content
//   s_*      in         coefficient pair, k-point weight; tlast ends a band
//   m_*      out        rounded overlap, power, running totals; tlast ends a run
//
// One coefficient pair is taken per cycle while the band queue can take a band end;
// a pair passes the input, product and sum registers before it reaches the accumulator.
// Each band end steps through the back end (round, square, sum, both partial weight
// products, combine, total); the four-entry queue holds bands that finish faster
// than the back end takes them, and the input stalls only when it is full.
// A result waits in the output register while the back end starts the next band.
// Reset clears the accumulators, both totals and all valid state.
`default_nettype none

module band_overlap_projector #(
    parameter int COEFF_WIDTH = 16,
    parameter int ACC_WIDTH   = 48
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    // proj_re, proj_im, ref_re, ref_im, kpoint_weight, zero fill
    input  wire  [((4*COEFF_WIDTH+bop_pkg::WEIGHT_W+7)/8)*8-1:0] s_tdata,
    input  wire                                   s_tlast,
    // band_occupied, last_item
    input  wire  [1:0]                            s_tuser,
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    // overlap_re, overlap_im, overlap_power, valence_sum, conduction_sum, zero fill
    output logic [bop_pkg::OUT_DATA_W-1:0]        m_tdata,
    output logic                                  m_tlast
);

    localparam int CW          = COEFF_WIDTH;
    localparam int QUEUE_DEPTH = 4;
    localparam int ENTRY_W     = 2 * ACC_WIDTH + $bits(bop_pkg::band_meta_t);
    localparam int OUT_USED_W  = 2 * bop_pkg::OVL_W + bop_pkg::POWER_W + 2 * bop_pkg::TOTAL_W;

    bop_pkg::band_meta_t                 in_meta, push_meta, pop_meta;
    logic                                push_valid, push_ready, pop_valid, pop_ready;
    logic signed [ACC_WIDTH-1:0]         push_acc_re, push_acc_im;
    logic signed [ACC_WIDTH-1:0]         pop_acc_re, pop_acc_im;
    logic        [ENTRY_W-1:0]           pop_data;
    logic signed [bop_pkg::OVL_W-1:0]    overlap_re, overlap_im;
    logic        [bop_pkg::POWER_W-1:0]  overlap_power;
    logic        [bop_pkg::TOTAL_W-1:0]  valence_sum, conduction_sum;

    assign in_meta.occupied = s_tuser[0];
    assign in_meta.weight   = s_tdata[4*CW +: bop_pkg::WEIGHT_W];
    assign in_meta.run_end  = s_tuser[1];

    bop_front #(
        .CW    (CW),
        .ACC_W (ACC_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .proj_re     (s_tdata[0*CW +: CW]),
        .proj_im     (s_tdata[1*CW +: CW]),
        .ref_re      (s_tdata[2*CW +: CW]),
        .ref_im      (s_tdata[3*CW +: CW]),
        .last_coeff  (s_tlast),
        .meta        (in_meta),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_acc_re (push_acc_re),
        .push_acc_im (push_acc_im),
        .push_meta   (push_meta)
    );

    bop_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_meta, push_acc_im, push_acc_re}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign pop_acc_re = pop_data[0 +: ACC_WIDTH];
    assign pop_acc_im = pop_data[ACC_WIDTH +: ACC_WIDTH];
    assign pop_meta   = pop_data[2*ACC_WIDTH +: $bits(bop_pkg::band_meta_t)];

    bop_back #(
        .CW    (CW),
        .ACC_W (ACC_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_acc_re     (pop_acc_re),
        .pop_acc_im     (pop_acc_im),
        .pop_meta       (pop_meta),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .overlap_re     (overlap_re),
        .overlap_im     (overlap_im),
        .overlap_power  (overlap_power),
        .valence_sum    (valence_sum),
        .conduction_sum (conduction_sum),
        .run_done       (m_tlast)
    );

    assign m_tdata = {{(bop_pkg::OUT_DATA_W - OUT_USED_W){1'b0}},
                      conduction_sum, valence_sum, overlap_power, overlap_im, overlap_re};

endmodule

`default_nettype wire

// ===== test/band_overlap_projector_test.sv =====
// Self-checking testbench for band_overlap_projector: streams coefficient pairs,
// predicts every band result in place and compares each field on the output.
// Depends on bop_pkg and the band_overlap_projector RTL.

module band_overlap_projector_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COEFF_W    = 16;
    localparam int ACC_W      = 48;
    localparam int S_DATA_W   = ((4*COEFF_W + bop_pkg::WEIGHT_W + 7) / 8) * 8;
    localparam int RND_SHIFT  = 2*(COEFF_W-1) - bop_pkg::OVL_FRAC;
    localparam int IDLE_LIMIT = 5000;
    localparam int LONG_BAND  = 40;

    localparam longint ACC_MAX = (longint'(1) <<< (ACC_W-1)) - 1;
    localparam longint ACC_MIN = -ACC_MAX - 1;
    localparam longint OVL_MAX = (longint'(1) <<< (bop_pkg::OVL_W-1)) - 1;
    localparam longint OVL_MIN = -OVL_MAX - 1;
    localparam bit [63:0] TOT_MAX = {1'b0, bop_pkg::TOTAL_MAX};

    localparam logic [COEFF_W-1:0] C_MIN = {1'b1, {(COEFF_W-1){1'b0}}};
    localparam logic [COEFF_W-1:0] C_MAX = {1'b0, {(COEFF_W-1){1'b1}}};

    typedef struct {
        logic signed [COEFF_W-1:0]    proj_re;
        logic signed [COEFF_W-1:0]    proj_im;
        logic signed [COEFF_W-1:0]    ref_re;
        logic signed [COEFF_W-1:0]    ref_im;
        logic                         last_coeff;
        logic                         band_occupied;
        logic [bop_pkg::WEIGHT_W-1:0] kpoint_weight;
        logic                         last_item;
    } coeff_req_t;

    typedef struct {
        logic [bop_pkg::OVL_W-1:0]   overlap_re;
        logic [bop_pkg::OVL_W-1:0]   overlap_im;
        logic [bop_pkg::POWER_W-1:0] overlap_power;
        logic [bop_pkg::TOTAL_W-1:0] valence_sum;
        logic [bop_pkg::TOTAL_W-1:0] conduction_sum;
        logic                        run_done;
    } band_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [S_DATA_W-1:0]           s_tdata = '0;
    logic                          s_tlast = 1'b0;
    logic [1:0]                    s_tuser = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [bop_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                          m_tlast;

    coeff_req_t   pending_q[$];
    band_result_t band_results_q[$];
    coeff_req_t   on_bus;

    // Predictor state.
    longint    acc_re;
    longint    acc_im;
    bit [63:0] valence_tot;
    bit [63:0] conduction_tot;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_count = 0;
    int coeff_count = 0;
    int band_count = 0;
    int run_count = 0;
    int idle_cycles = 0;

    band_overlap_projector #(
        .COEFF_WIDTH(COEFF_W),
        .ACC_WIDTH  (ACC_W)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always #5 clk = ~clk;

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // Floor of the fraction drop plus the first dropped bit gives round half up.
    function automatic longint round_q23(longint v);
        longint q;
        q = (v >>> RND_SHIFT) + ((v >>> (RND_SHIFT-1)) & 1);
        return clamp(q, OVL_MIN, OVL_MAX);
    endfunction

    function automatic bit [63:0] add_total(bit [63:0] t, bit [63:0] x);
        if (x > TOT_MAX - t)
            return TOT_MAX;
        return t + x;
    endfunction

    function automatic void predict_band(coeff_req_t r);
        longint       prod_re;
        longint       prod_im;
        longint       ovl_re;
        longint       ovl_im;
        bit [63:0]    power;
        bit [63:0]    weighted;
        band_result_t res;
        prod_re = longint'(r.proj_re) * longint'(r.ref_re)
                + longint'(r.proj_im) * longint'(r.ref_im);
        prod_im = longint'(r.proj_im) * longint'(r.ref_re)
                - longint'(r.proj_re) * longint'(r.ref_im);
        acc_re = clamp(acc_re + prod_re, ACC_MIN, ACC_MAX);
        acc_im = clamp(acc_im + prod_im, ACC_MIN, ACC_MAX);
        if (!r.last_coeff)
            return;
        ovl_re = round_q23(acc_re);
        ovl_im = round_q23(acc_im);
        power = ovl_re * ovl_re + ovl_im * ovl_im;
        weighted = power * 64'(r.kpoint_weight);
        if (r.band_occupied)
            valence_tot = add_total(valence_tot, weighted);
        else
            conduction_tot = add_total(conduction_tot, weighted);
        res.overlap_re = ovl_re[bop_pkg::OVL_W-1:0];
        res.overlap_im = ovl_im[bop_pkg::OVL_W-1:0];
        res.overlap_power = power[bop_pkg::POWER_W-1:0];
        res.valence_sum = valence_tot[bop_pkg::TOTAL_W-1:0];
        res.conduction_sum = conduction_tot[bop_pkg::TOTAL_W-1:0];
        res.run_done = r.last_item;
        band_results_q.push_back(res);
        acc_re = 0;
        acc_im = 0;
        if (r.last_item)
        begin
            valence_tot = 0;
            conduction_tot = 0;
        end
    endfunction

    function automatic coeff_req_t make_req(logic [COEFF_W-1:0] pr, logic [COEFF_W-1:0] pi,
                                            logic [COEFF_W-1:0] rr, logic [COEFF_W-1:0] ri,
                                            logic lc, logic occ,
                                            logic [bop_pkg::WEIGHT_W-1:0] w, logic li);
        coeff_req_t r;
        r.proj_re = pr;
        r.proj_im = pi;
        r.ref_re = rr;
        r.ref_im = ri;
        r.last_coeff = lc;
        r.band_occupied = occ;
        r.kpoint_weight = w;
        r.last_item = li;
        return r;
    endfunction

    function automatic logic [COEFF_W-1:0] rand_coeff();
        case ($urandom_range(7))
            0: return C_MIN;
            1: return C_MAX;
            2: return '0;
            default: return COEFF_W'($urandom);
        endcase
    endfunction

    function automatic logic [bop_pkg::WEIGHT_W-1:0] rand_weight();
        case ($urandom_range(5))
            0: return '1;
            1: return '0;
            default: return bop_pkg::WEIGHT_W'($urandom);
        endcase
    endfunction

    // Queues random bands, mostly short with an occasional long one, always
    // closing the last band so that every phase drains completely.
    task automatic queue_random_bands(int n_items);
        int queued;
        int len;
        logic lc;
        queued = 0;
        while (queued < n_items)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
            begin
                lc = (i == len-1);
                pending_q.push_back(make_req(rand_coeff(), rand_coeff(), rand_coeff(),
                                             rand_coeff(), lc, 1'($urandom), rand_weight(),
                                             lc ? ($urandom_range(11) == 0)
                                                : ($urandom_range(9) == 0)));
            end
            queued += len;
        end
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || s_tvalid || band_results_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic check_field(string name, bit [63:0] expected, bit [63:0] actual);
        if (expected !== actual)
        begin
            $error("%s: expected %0h, got %0h", name, expected, actual);
            mismatch_count++;
        end
    endtask

    // Driver: keeps a request on the bus until it is taken, predicting on acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tlast <= 1'b0;
            s_tuser <= '0;
            acc_re = 0;
            acc_im = 0;
            valence_tot = 0;
            conduction_tot = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_band(on_bus);
                coeff_count++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    on_bus = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {on_bus.kpoint_weight, on_bus.ref_im, on_bus.ref_re,
                                on_bus.proj_im, on_bus.proj_re};
                    s_tlast <= on_bus.last_coeff;
                    s_tuser <= {on_bus.last_item, on_bus.band_occupied};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure and field-by-field comparison of each result.
    always @(posedge clk or negedge rst_n)
    begin
        band_result_t exp_res;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                band_count++;
                if (band_results_q.size() == 0)
                begin
                    $error("unexpected result: data %0h, tlast %b", m_tdata, m_tlast);
                    mismatch_count++;
                end
                else
                begin
                    exp_res = band_results_q.pop_front();
                    if (exp_res.run_done)
                        run_count++;
                    check_field("overlap_re", exp_res.overlap_re, m_tdata[0 +: 24]);
                    check_field("overlap_im", exp_res.overlap_im, m_tdata[24 +: 24]);
                    check_field("overlap_power", exp_res.overlap_power, m_tdata[48 +: 48]);
                    check_field("valence_sum", exp_res.valence_sum, m_tdata[96 +: 63]);
                    check_field("conduction_sum", exp_res.conduction_sum, m_tdata[159 +: 63]);
                    check_field("run_done", exp_res.run_done, m_tlast);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 13;
        recv_idle_pct = 51;
        // Zero band, then round half up on a positive and a negative half step.
        pending_q.push_back(make_req('0, '0, '0, '0, 1'b1, 1'b0, '0, 1'b0));
        pending_q.push_back(make_req(16'sd1, '0, 16'sd64, '0, 1'b1, 1'b1, '1, 1'b0));
        pending_q.push_back(make_req(-16'sd1, '0, 16'sd64, '0, 1'b1, 1'b0, '1, 1'b0));
        // Overlap saturated high in both parts; two such bands saturate the valence total.
        for (int i = 0; i < 2; i++)
        begin
            pending_q.push_back(make_req(C_MIN, C_MIN, C_MIN, C_MIN, 1'b0, 1'b1, '1, 1'b0));
            pending_q.push_back(make_req(C_MIN, C_MIN, C_MIN, C_MAX, 1'b1, 1'b1, '1, 1'b0));
        end
        // Same for the conduction total; a last item away from a band end is ignored.
        pending_q.push_back(make_req(C_MIN, C_MIN, C_MIN, C_MIN, 1'b0, 1'b0, '1, 1'b1));
        pending_q.push_back(make_req(C_MIN, C_MIN, C_MIN, C_MAX, 1'b1, 1'b0, '1, 1'b0));
        pending_q.push_back(make_req(C_MIN, C_MIN, C_MIN, C_MIN, 1'b0, 1'b0, '1, 1'b0));
        pending_q.push_back(make_req(C_MIN, C_MIN, C_MIN, C_MAX, 1'b1, 1'b0, '1, 1'b1));
        // Totals restart after the run end; overlap saturated low, zero weight.
        pending_q.push_back(make_req(C_MIN, C_MAX, C_MAX, C_MIN, 1'b1, 1'b1, '0, 1'b0));
        pending_q.push_back(make_req(C_MAX, C_MAX, C_MAX, C_MAX, 1'b1, 1'b1, '1, 1'b0));
        pending_q.push_back(make_req(C_MAX, C_MIN, C_MIN, C_MAX, 1'b0, 1'b1, 16'h8000, 1'b0));
        pending_q.push_back(make_req(C_MIN, C_MAX, C_MAX, C_MIN, 1'b1, 1'b0, 16'h0001, 1'b0));
        pending_q.push_back(make_req(16'h5555, 16'hAAAA, 16'h3333, 16'hCCCC,
                                     1'b1, 1'b1, 16'h1234, 1'b1));
        queue_random_bands(450);
        wait_drained();

        send_idle_pct = 51;
        recv_idle_pct = 13;
        queue_random_bands(470);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // Two long back-to-back bands, the first of large positive then negative products.
        for (int i = 0; i < LONG_BAND; i++)
            pending_q.push_back(make_req(C_MIN, C_MIN, C_MIN, C_MIN, 1'b0, 1'b1, '1, 1'b0));
        for (int i = 0; i < 100; i++)
            pending_q.push_back(make_req(C_MIN, C_MIN, C_MAX, C_MAX, i == 99, 1'b1, '1, 1'b0));
        for (int i = 0; i < LONG_BAND; i++)
            pending_q.push_back(make_req(C_MIN, C_MIN, C_MAX, C_MIN,
                                         i == LONG_BAND-1, 1'b0, '1, 1'b0));
        queue_random_bands(300);
        wait_drained();

        repeat (40) @(negedge clk);
        if (band_results_q.size() != 0)
        begin
            $error("%0d expected results never arrived", band_results_q.size());
            mismatch_count++;
        end
        $display("Covered %0d coefficient requests and %0d band results (%0d run ends)",
                 coeff_count, band_count, run_count);
        $display("across three idle patterns, with overlap and total saturation and long bands.");
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
